/* hw/rtl/ede_pkg.sv */
// Shared constants, codes and types of the edit distance engine.
`default_nettype none
package ede_pkg;
	localparam int MAX_LEN = 64;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SYM_W   = 8;
	localparam int MODE_W  = 2;
	localparam int DIST_W  = 7;

	localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_sym_en;
		logic [SYM_W-1:0]  wr_sym;
		logic [LEN_W-1:0]  wr_row;
	} mem_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} res_t;
endpackage
`default_nettype wire

/* hw/rtl/ede_item_if.sv */
// Input channel of the edit distance engine: one string byte or command per beat.
`default_nettype none
interface ede_item_if
	import ede_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SYM_W-1:0]  symbol;

	modport source (output valid, output mode, output symbol, input ready);
	modport sink (input valid, input mode, input symbol, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ede_result_if.sv */
// Output channel of the edit distance engine: one distance per beat.
`default_nettype none
interface ede_result_if
	import ede_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              overflow;

	modport source (output valid, output distance, output overflow, input ready);
	modport sink (input valid, input distance, input overflow, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ede_store.sv */
// First-string memory and distance row memory, one read and one write port each.
`default_nettype none
module ede_store
	import ede_pkg::*;
(
	input  wire logic             clk,
	input  wire mem_req_t         req,
	output logic [SYM_W-1:0]      rd_sym,
	output logic [LEN_W-1:0]      rd_row
);
	logic [SYM_W-1:0] sym_mem [MAX_LEN];
	logic [LEN_W-1:0] row_mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			row_mem[req.wr_addr] <= req.wr_row;
		end
		if (req.wr_en && req.wr_sym_en) begin
			sym_mem[req.wr_addr] <= req.wr_sym;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_sym <= sym_mem[req.rd_addr];
			rd_row <= row_mem[req.rd_addr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ede_ctrl.sv */
// Sequencer and row update datapath of the edit distance engine.
`default_nettype none
module ede_ctrl
	import ede_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	ede_item_if.sink              item,
	output mem_req_t              req,
	input  wire logic [SYM_W-1:0] rd_sym,
	input  wire logic [LEN_W-1:0] rd_row,
	output logic                  res_valid,
	output res_t                  res,
	input  wire logic             res_ready
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [LEN_W-1:0]  first_len_q;
	logic [LEN_W-1:0]  second_len_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  row0_q;
	logic [SYM_W-1:0]  sym_q;
	logic [LEN_W-1:0]  idx_q;
	logic              rd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [LEN_W-1:0]  left_q;
	logic [LEN_W-1:0]  diag_q;
	logic [LEN_W-1:0]  res_row_q;
	logic              res_mem_q;
	logic              res_ovf_q;

	logic              accept;
	logic              scan_issue;
	logic              scan_last;
	logic [LEN_W:0]    above_inc;
	logic [LEN_W:0]    left_inc;
	logic [LEN_W:0]    diag_cost;
	logic [LEN_W:0]    cell_min;
	logic [LEN_W-1:0]  cell_val;
	logic [LEN_W-1:0]  fin_row;
	logic [LEN_W+DIST_W-1:0] fin_wide;
	logic [LEN_W-1:0]  first_last;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < first_len_q);
	assign first_last = first_len_q - LEN_W'(1);
	assign scan_last  = rd_s1 && (addr_s1 == first_last[ADDR_W-1:0]);

	// One dynamic-programming cell: minimum of delete, insert and substitute.
	always_comb begin
		above_inc = {1'b0, rd_row} + (LEN_W+1)'(1);
		left_inc  = {1'b0, left_q} + (LEN_W+1)'(1);
		diag_cost = {1'b0, diag_q} + (LEN_W+1)'(rd_sym != sym_q);
		cell_min  = (above_inc < left_inc) ? above_inc : left_inc;
		if (diag_cost < cell_min) begin
			cell_min = diag_cost;
		end
		cell_val = cell_min[LEN_W-1:0];
	end

	always_comb begin
		req = '0;
		if (accept && item.mode == MODE_FIRST && second_len_q == '0
				&& first_len_q < LEN_W'(MAX_LEN)) begin
			req.wr_en     = 1'b1;
			req.wr_sym_en = 1'b1;
			req.wr_addr   = first_len_q[ADDR_W-1:0];
			req.wr_sym    = item.symbol;
			req.wr_row    = first_len_q + LEN_W'(1);
		end else if (rd_s1) begin
			req.wr_en   = 1'b1;
			req.wr_addr = addr_s1;
			req.wr_row  = cell_val;
		end
		if (accept && item.mode == MODE_FINISH && first_len_q != '0) begin
			req.rd_en   = 1'b1;
			req.rd_addr = first_last[ADDR_W-1:0];
		end else if (scan_issue) begin
			req.rd_en   = 1'b1;
			req.rd_addr = idx_q[ADDR_W-1:0];
		end
	end

	assign fin_row       = res_mem_q ? rd_row : res_row_q;
	assign fin_wide      = {{DIST_W{1'b0}}, fin_row};
	assign res_valid     = (state_q == ST_FIN);
	assign res.distance  = fin_wide[DIST_W-1:0];
	assign res.overflow  = res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_len_q  <= '0;
			second_len_q <= '0;
			ovf_q        <= 1'b0;
			row0_q       <= '0;
			idx_q        <= '0;
			rd_s1        <= 1'b0;
		end else begin
			rd_s1 <= scan_issue;
			if (scan_issue) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_FIRST: begin
								if (second_len_q != '0 || first_len_q >= LEN_W'(MAX_LEN)) begin
									ovf_q <= 1'b1;
								end else begin
									first_len_q <= first_len_q + LEN_W'(1);
								end
							end
							MODE_SECOND: begin
								if (second_len_q >= LEN_W'(MAX_LEN)) begin
									ovf_q <= 1'b1;
								end else begin
									second_len_q <= second_len_q + LEN_W'(1);
									row0_q       <= second_len_q + LEN_W'(1);
									idx_q        <= '0;
									if (first_len_q != '0) begin
										state_q <= ST_SCAN;
									end
								end
							end
							MODE_FINISH: begin
								first_len_q  <= '0;
								second_len_q <= '0;
								ovf_q        <= 1'b0;
								row0_q       <= '0;
								state_q      <= ST_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the row sweep and of the pending result.
	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_SECOND) begin
			sym_q  <= item.symbol;
			diag_q <= row0_q;
			left_q <= second_len_q + LEN_W'(1);
		end else if (rd_s1) begin
			diag_q <= rd_row;
			left_q <= cell_val;
		end
		if (scan_issue) begin
			addr_s1 <= idx_q[ADDR_W-1:0];
		end
		if (accept && item.mode == MODE_FINISH) begin
			res_row_q <= row0_q;
			res_mem_q <= (first_len_q != '0);
			res_ovf_q <= ovf_q;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_len_q <= LEN_W'(MAX_LEN) && second_len_q <= LEN_W'(MAX_LEN))
		else $error("string length beyond capacity");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> ({1'b0, addr_s1} < (ADDR_W+1)'(first_len_q)))
		else $error("row update beyond first string");

	a_sweep_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> state_q == ST_SCAN)
		else $error("row update outside of a sweep");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == MODE_FINISH) |=> (first_len_q == '0 && second_len_q == '0
			&& !ovf_q && row0_q == '0))
		else $error("finish did not clear the pair");
endmodule
`default_nettype wire

/* hw/rtl/edit_distance_engine.sv */
// Top level of the edit distance engine: sequencer, memories and result register.
// A first-string byte is stored on acceptance; a second-string byte starts a sweep over the
// row memory, one entry per cycle, that updates entries one to L, the current first-string length.
// A finish beat reads the last row entry, and the sequencer offers it to the output register.
// The item port is busy during a sweep and until a finished result moves on.
// Reset clears lengths, overflow flag and row entry zero at once; no memory clearing pass.
`default_nettype none
module edit_distance_engine
	import ede_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	ede_item_if.sink     item,
	ede_result_if.source result
);
	mem_req_t         req;
	logic [SYM_W-1:0] rd_sym;
	logic [LEN_W-1:0] rd_row;
	logic             res_valid;
	res_t             res;
	logic             res_ready;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_ovf_q;

	// The sequencer owns the handshake on the item side and drives both memories.
	ede_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.req       (req),
		.rd_sym    (rd_sym),
		.rd_row    (rd_row),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// First string bytes and distance row entries one to L share one address per step.
	ede_store u_store (
		.clk    (clk),
		.req    (req),
		.rd_sym (rd_sym),
		.rd_row (rd_row)
	);

	// The output register takes a new result when it is empty or being drained this cycle,
	// so the item side is free again while a result still waits downstream.
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_dist_q <= res.distance;
			out_ovf_q  <= res.overflow;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.overflow = out_ovf_q;

	a_no_result_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("pending result dropped");

	a_item_blocked_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !item.ready)
		else $error("item taken while a result is pending in the sequencer");

	a_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> out_valid_q)
		else $error("result register not filled");
endmodule
`default_nettype wire

/* bench/edit_distance_checker.sv */
`timescale 1ns / 1ps
// Predicts edit distance results from accepted input beats and compares them with result beats.
module edit_distance_checker
	import ede_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ede_item_if       item,
	ede_result_if     result,
	input  wire logic end_of_test,
	output int        fail_count,
	output int        pending
);
	logic [SYM_W-1:0] first_bytes [MAX_LEN];
	int unsigned      dist_row [MAX_LEN+1];
	int unsigned      first_len;
	int unsigned      second_len;
	logic             overflow_seen;
	logic             leftovers_checked;
	res_t             expected_results [$];

	// Advances the edit distance state by one beat and queues a result on a finish.
	task automatic apply_beat(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym);
		int unsigned diag;
		int unsigned above;
		int unsigned best;
		int unsigned col;
		res_t        res;
		case (mode)
			MODE_FIRST: begin
				if (second_len != 0 || first_len >= MAX_LEN) begin
					overflow_seen = 1'b1;
				end else begin
					first_bytes[first_len] = sym;
					first_len++;
					dist_row[first_len] = first_len;
				end
			end
			MODE_SECOND: begin
				if (second_len >= MAX_LEN) begin
					overflow_seen = 1'b1;
				end else begin
					diag = dist_row[0];
					second_len++;
					dist_row[0] = second_len;
					for (col = 1; col <= first_len; col++) begin
						above = dist_row[col];
						best = (above < dist_row[col-1]) ? above + 1 : dist_row[col-1] + 1;
						if (diag + ((first_bytes[col-1] == sym) ? 0 : 1) < best)
							best = diag + ((first_bytes[col-1] == sym) ? 0 : 1);
						diag = above;
						dist_row[col] = best;
					end
				end
			end
			MODE_FINISH: begin
				res.distance = DIST_W'(dist_row[first_len]);
				res.overflow = overflow_seen;
				expected_results.push_back(res);
				first_len = 0;
				second_len = 0;
				overflow_seen = 1'b0;
				dist_row[0] = 0;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		res_t oldest;
		if (!arst_n) begin
			first_len = 0;
			second_len = 0;
			overflow_seen = 1'b0;
			dist_row[0] = 0;
			expected_results.delete();
			fail_count = 0;
			leftovers_checked = 1'b0;
		end else begin
			// A finish shows its result no earlier than the edge after it is taken, so the
			// order of these two steps within one edge does not matter.
			if (item.valid && item.ready)
				apply_beat(item.mode, item.symbol);
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("Unexpected result beat: distance %0d, overflow %0b",
						result.distance, result.overflow);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (result.distance !== oldest.distance) begin
						$error("Field distance: expected %0d, actual %0d",
							oldest.distance, result.distance);
						fail_count++;
					end
					if (result.overflow !== oldest.overflow) begin
						$error("Field overflow: expected %0b, actual %0b",
							oldest.overflow, result.overflow);
						fail_count++;
					end
				end
			end
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_results.size() != 0) begin
					$error("%0d expected results never arrived", expected_results.size());
					fail_count++;
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Top of the edit distance engine testbench: clock, reset, stimulus, handshake pacing and verdict.
module testbench;
	import ede_pkg::*;

	// Number of data and finish beats the run aims for, directed part included.
	localparam int ITEM_TARGET = 800;
	// Finished pairs the run should reach before it stops.
	localparam int FINISH_TARGET = 40;
	// Near the end of the run both sides stop idling.
	localparam int QUIET_TAIL = 100;
	// The longest second-string sweep touches every row entry once; the drain wait is sized from it.
	localparam int DRAIN_CYCLES = 2 * (MAX_LEN + 2);
	// Worst quiet stretch of a correct run is a sender gap, a full sweep and a receiver stall;
	// the limit is many times that.
	localparam int WATCHDOG_LIMIT = 20 * (MAX_LEN + 2 * 13 + 4);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic end_of_test = 1'b0;
	int   fail_count;
	int   pending;

	// Stimulus bookkeeping. Ignored no-operation beats are not counted as items.
	int   sent_items = 0;
	int   sent_finishes = 0;
	int   pair_index = 0;
	bit   allow_idle = 1'b1;
	int   idle_odds = 20;
	int   quiet_cycles = 0;

	ede_item_if   item_ch ();
	ede_result_if result_ch ();

	edit_distance_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	edit_distance_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.end_of_test (end_of_test),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sends one beat on the item channel. It is called at a falling edge and returns at the
	// falling edge after the beat was taken, so valid stays high across back-to-back beats.
	// Before the beat the sender may go quiet for a random burst with junk on the payload.
	task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym);
		int gap;
		if (allow_idle && $urandom_range(0, 99) < idle_odds) begin
			item_ch.valid = 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) begin
				item_ch.mode = MODE_W'($urandom_range(0, 3));
				item_ch.symbol = SYM_W'($urandom_range(0, 255));
				@(negedge clk);
			end
		end
		item_ch.valid = 1'b1;
		item_ch.mode = mode;
		item_ch.symbol = sym;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
		if (mode != MODE_NOP)
			sent_items++;
		if (mode == MODE_FINISH)
			sent_finishes++;
	endtask

	// A small alphabet around a random base gives many matching bytes; zero means any byte.
	function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] base,
		input int alphabet);
		if (alphabet == 0)
			return SYM_W'($urandom_range(0, 255));
		return base ^ SYM_W'($urandom_range(0, alphabet - 1));
	endfunction

	// Loads one string pair and finishes it. Now and then a no-operation beat slips in, and
	// sometimes a first-string byte arrives after the second string has started, which the
	// block must drop and flag.
	task automatic run_pair(input int len_first, input int len_second, input int alphabet);
		logic [SYM_W-1:0] base;
		int               k;
		base = SYM_W'($urandom_range(0, 255));
		for (k = 0; k < len_first; k++) begin
			if ($urandom_range(0, 24) == 0)
				send_beat(MODE_NOP, SYM_W'($urandom_range(0, 255)));
			send_beat(MODE_FIRST, pick_symbol(base, alphabet));
		end
		for (k = 0; k < len_second; k++) begin
			if ($urandom_range(0, 24) == 0)
				send_beat(MODE_NOP, SYM_W'($urandom_range(0, 255)));
			send_beat(MODE_SECOND, pick_symbol(base, alphabet));
			if (k == 0 && $urandom_range(0, 11) == 0)
				send_beat(MODE_FIRST, pick_symbol(base, alphabet));
		end
		send_beat(MODE_FINISH, SYM_W'($urandom_range(0, 255)));
	endtask

	// The receiver stalls in random bursts while idling is allowed.
	always begin
		@(negedge clk);
		if (allow_idle && $urandom_range(0, 99) < idle_odds) begin
			result_ch.ready = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		result_ch.ready = 1'b1;
	end

	// The watchdog ends a run that stops moving beats on either channel.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int len_first;
		int len_second;
		int alphabet;
		int beats;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_NOP;
		item_ch.symbol = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Both strings empty gives zero.
		send_beat(MODE_FINISH, 8'h00);
		// Only the first string, with the lowest and highest byte values.
		send_beat(MODE_FIRST, 8'h00);
		send_beat(MODE_FIRST, 8'hFF);
		send_beat(MODE_FINISH, 8'hFF);
		// Only the second string.
		send_beat(MODE_SECOND, 8'h7F);
		send_beat(MODE_SECOND, 8'h80);
		send_beat(MODE_FINISH, 8'h55);
		// Mixed strings with a no-operation beat in the middle, which must change nothing.
		send_beat(MODE_FIRST, 8'h00);
		send_beat(MODE_FIRST, 8'hFF);
		send_beat(MODE_NOP, 8'hA5);
		send_beat(MODE_FIRST, 8'h5A);
		send_beat(MODE_SECOND, 8'hFF);
		send_beat(MODE_SECOND, 8'h00);
		send_beat(MODE_SECOND, 8'h5A);
		send_beat(MODE_FINISH, 8'h00);
		// A first-string byte after the second string started is dropped and flagged.
		send_beat(MODE_FIRST, 8'h41);
		send_beat(MODE_SECOND, 8'h41);
		send_beat(MODE_FIRST, 8'h42);
		send_beat(MODE_FINISH, 8'h00);
		// Identical strings give zero, and the flag from the last pair must be gone.
		send_beat(MODE_FIRST, 8'hA5);
		send_beat(MODE_FIRST, 8'hA5);
		send_beat(MODE_SECOND, 8'hA5);
		send_beat(MODE_SECOND, 8'hA5);
		send_beat(MODE_FINISH, 8'h00);

		// Random part. Most pairs are short and well formed; a few fill or overrun the
		// string capacity, and some are runs of arbitrary beats.
		while (sent_items < ITEM_TARGET || sent_finishes < FINISH_TARGET) begin
			allow_idle = (sent_items < ITEM_TARGET - QUIET_TAIL);
			case ($urandom_range(0, 2))
				0: idle_odds = 0;
				1: idle_odds = 15;
				default: idle_odds = 40;
			endcase
			case ($urandom_range(0, 2))
				0: alphabet = 0;
				1: alphabet = 2;
				default: alphabet = 4;
			endcase
			len_first = $urandom_range(0, 8);
			len_second = $urandom_range(0, 8);
			if (pair_index == 3) begin
				// First string overruns; with an empty second string the distance is the
				// full capacity.
				len_first = MAX_LEN + $urandom_range(1, 2);
				len_second = 0;
			end else if (pair_index == 8) begin
				len_first = $urandom_range(0, 4);
				len_second = MAX_LEN + $urandom_range(1, 2);
			end else if (pair_index == 12) begin
				len_first = MAX_LEN;
				len_second = MAX_LEN;
			end else if ($urandom_range(0, 39) == 0) begin
				len_first = $urandom_range(MAX_LEN - 8, MAX_LEN + 2);
				len_second = $urandom_range(MAX_LEN - 8, MAX_LEN + 2);
			end
			if (pair_index > 12 && $urandom_range(0, 9) == 0) begin
				beats = $urandom_range(1, 6);
				repeat (beats)
					send_beat(MODE_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
			end else begin
				run_pair(len_first, len_second, alphabet);
			end
			pair_index++;
		end

		// Drain: wait for every expected result, then give the block time to show anything
		// it should not.
		allow_idle = 1'b0;
		item_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		end_of_test = 1'b1;
		repeat (2) @(negedge clk);

		$display("Run covered %0d string and finish beats over %0d finished pairs,",
			sent_items, sent_finishes);
		$display("with empty, identical, full and overrunning strings and late first bytes.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
